// ----- hw/rtl/aphc_pkg.sv -----
// Package for the packet header checker: types, status and register codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package aphc_pkg;

    // Header layout
    localparam int HEADER_BYTES = 20;
    localparam int HDR_WORDS    = 5;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Queue depth between the front and the back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Verdict codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_MAGIC    = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_OPCODE   = 3'd4;
    localparam logic [2:0] ST_ZERO_ID  = 3'd5;
    localparam logic [2:0] ST_TOO_BIG  = 3'd6;
    localparam logic [2:0] ST_LENGTH   = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_VERSION = 3'd1;
    localparam logic [2:0] CFG_OP_MIN  = 3'd2;
    localparam logic [2:0] CFG_OP_MAX  = 3'd3;
    localparam logic [2:0] CFG_MAX_PAY = 3'd4;

    localparam logic [31:0] MAX_PAY_RESET = 32'd65536;

    // Configuration register set
    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] version;
        logic [31:0] op_min;
        logic [31:0] op_max;
        logic [31:0] max_payload;
    } t_cfg;

    // One classified beat handed from the front to the back
    typedef struct packed {
        logic        payload;
        logic [7:0]  data_byte;
        logic        eop;
        logic        short_pkt;
        logic        len_bad;
        logic [31:0] magic;
        logic [31:0] version;
        logic [31:0] opcode;
        logic [31:0] request_id;
        logic [31:0] payload_size;
    } t_qent;

endpackage

// ----- hw/rtl/aphc_front.sv -----
// Front part: accepts bytes, counts them, assembles the header words and
// classifies each beat for the queue. Depends on aphc_pkg.
`timescale 1ns / 1ps

module aphc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_packet,
    output logic                o_push,
    output aphc_pkg::t_qent     o_entry
);

    logic [31:0] r_count, n_count;
    logic [31:0] r_hdr [aphc_pkg::HDR_WORDS];
    logic [31:0] n_hdr [aphc_pkg::HDR_WORDS];
    logic [31:0] w_hdr [aphc_pkg::HDR_WORDS];
    logic        w_payload;
    logic [31:0] w_length;
    logic [32:0] w_want;

    assign w_payload = (r_count >= 32'(aphc_pkg::HEADER_BYTES));

    // Insert the incoming byte into its header word while inside the header.
    always_comb begin
        for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
            w_hdr[w] = r_hdr[w];
        end
        for (int k = 0; k < aphc_pkg::HEADER_BYTES; k++) begin
            if (!w_payload && (r_count[4:0] == 5'(k))) begin
                w_hdr[k / 4][(k % 4) * 8 +: 8] = i_data_byte;
            end
        end
    end

    // Saturating length including this byte, and the length the header declares.
    assign w_length = (r_count == aphc_pkg::COUNT_MAX) ? r_count : r_count + 32'd1;
    assign w_want   = 33'(aphc_pkg::HEADER_BYTES) + {1'b0, w_hdr[4]};

    // Next state: the counter and header words clear after the final byte.
    always_comb begin
        n_count = r_count;
        for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
            n_hdr[w] = r_hdr[w];
        end
        if (i_accept) begin
            if (i_end_of_packet) begin
                n_count = '0;
                for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
                    n_hdr[w] = '0;
                end
            end else begin
                n_count = w_length;
                for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
                    n_hdr[w] = w_hdr[w];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
                r_hdr[w] <= '0;
            end
        end else begin
            r_count <= n_count;
            for (int w = 0; w < aphc_pkg::HDR_WORDS; w++) begin
                r_hdr[w] <= n_hdr[w];
            end
        end
    end

    // A beat yields a result when it is payload or ends the packet.
    assign o_push = i_valid && i_accept && (w_payload || i_end_of_packet);

    always_comb begin
        o_entry.payload      = w_payload;
        o_entry.data_byte    = w_payload ? i_data_byte : 8'd0;
        o_entry.eop          = i_end_of_packet;
        o_entry.short_pkt    = (w_length < 32'(aphc_pkg::HEADER_BYTES));
        o_entry.len_bad      = (w_length == aphc_pkg::COUNT_MAX) ||
                               ({1'b0, w_length} != w_want);
        o_entry.magic        = w_hdr[0];
        o_entry.version      = w_hdr[1];
        o_entry.opcode       = w_hdr[2];
        o_entry.request_id   = w_hdr[3];
        o_entry.payload_size = w_hdr[4];
    end

endmodule

// ----- hw/rtl/aphc_queue.sv -----
// Short first-in first-out queue of classified beats between front and back.
// Depends on aphc_pkg.
`timescale 1ns / 1ps

module aphc_queue #(
    parameter int DEPTH = aphc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  aphc_pkg::t_qent     i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output aphc_pkg::t_qent     o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aphc_pkg::t_qent   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_entry    = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ----- hw/rtl/aphc_back.sv -----
// Back part: takes classified beats from the queue, works out the verdict
// and holds the result beat in the output register. Depends on aphc_pkg.
`timescale 1ns / 1ps

module aphc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aphc_pkg::t_cfg      i_cfg,
    input  logic                i_q_nonempty,
    input  aphc_pkg::t_qent     i_q_entry,
    output logic                o_q_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_payload_valid,
    output logic [7:0]          o_payload_byte,
    output logic                o_packet_done,
    output logic [2:0]          o_status,
    output logic [31:0]         o_opcode,
    output logic [31:0]         o_request_id,
    output logic [31:0]         o_payload_size
);

    logic        r_valid, n_valid;
    logic        r_pay_valid;
    logic [7:0]  r_pay_byte;
    logic        r_done;
    logic [2:0]  r_status;
    logic [31:0] r_opcode, r_req_id, r_size;

    logic [2:0]  w_status;
    logic        w_fields;

    // Take a beat whenever the output register is empty or being emptied.
    assign o_q_pop = i_q_nonempty && (!r_valid || i_out_ready);

    // Verdict, checked in priority order.
    always_comb begin
        if (i_q_entry.short_pkt) begin
            w_status = aphc_pkg::ST_SHORT;
        end else if (i_q_entry.magic != i_cfg.magic) begin
            w_status = aphc_pkg::ST_MAGIC;
        end else if (i_q_entry.version != i_cfg.version) begin
            w_status = aphc_pkg::ST_VERSION;
        end else if ((i_q_entry.opcode < i_cfg.op_min) ||
                     (i_q_entry.opcode > i_cfg.op_max)) begin
            w_status = aphc_pkg::ST_OPCODE;
        end else if (i_q_entry.request_id == 32'd0) begin
            w_status = aphc_pkg::ST_ZERO_ID;
        end else if (i_q_entry.payload_size > i_cfg.max_payload) begin
            w_status = aphc_pkg::ST_TOO_BIG;
        end else if (i_q_entry.len_bad) begin
            w_status = aphc_pkg::ST_LENGTH;
        end else begin
            w_status = aphc_pkg::ST_OK;
        end
    end

    // Header fields are reported only on a verdict that is not a short packet.
    assign w_fields = i_q_entry.eop && !i_q_entry.short_pkt;

    always_comb begin
        n_valid = r_valid;
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pay_valid <= i_q_entry.payload;
            r_pay_byte  <= i_q_entry.data_byte;
            r_done      <= i_q_entry.eop;
            r_status    <= i_q_entry.eop ? w_status : aphc_pkg::ST_OK;
            r_opcode    <= w_fields ? i_q_entry.opcode : 32'd0;
            r_req_id    <= w_fields ? i_q_entry.request_id : 32'd0;
            r_size      <= w_fields ? i_q_entry.payload_size : 32'd0;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_payload_valid = r_pay_valid;
    assign o_payload_byte  = r_pay_byte;
    assign o_packet_done   = r_done;
    assign o_status        = r_status;
    assign o_opcode        = r_opcode;
    assign o_request_id    = r_req_id;
    assign o_payload_size  = r_size;

endmodule

// ----- hw/rtl/admin_packet_header_checker.sv -----
// Packet header checker: one byte per cycle while o_ready is high, result beats
// for payload bytes and for the final byte. An accepted beat is written into
// the queue and then moves into the output register when the queue pops it;
// throughput is one byte per cycle while i_ready holds, set by the queue pop
// into the output register. Reset is synchronous: it empties the queue and
// output, clears the counter and header words, and returns the registers to
// their defaults.
`timescale 1ns / 1ps

module admin_packet_header_checker #(
    parameter int QUEUE_DEPTH = aphc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_data_byte,
    input  logic         i_end_of_packet,
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_payload_valid,
    output logic [7:0]   o_payload_byte,
    output logic         o_packet_done,
    output logic [2:0]   o_status,
    output logic [31:0]  o_opcode,
    output logic [31:0]  o_request_id,
    output logic [31:0]  o_payload_size
);

    aphc_pkg::t_cfg   r_cfg, n_cfg;
    aphc_pkg::t_qent  w_push_entry, w_pop_entry;
    logic             w_push, w_pop, w_full, w_nonempty;

    // Configuration register writes; unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                aphc_pkg::CFG_MAGIC:   n_cfg.magic       = i_cfg_data;
                aphc_pkg::CFG_VERSION: n_cfg.version     = i_cfg_data;
                aphc_pkg::CFG_OP_MIN:  n_cfg.op_min      = i_cfg_data;
                aphc_pkg::CFG_OP_MAX:  n_cfg.op_max      = i_cfg_data;
                aphc_pkg::CFG_MAX_PAY: n_cfg.max_payload = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic       <= '0;
            r_cfg.version     <= '0;
            r_cfg.op_min      <= '0;
            r_cfg.op_max      <= '0;
            r_cfg.max_payload <= aphc_pkg::MAX_PAY_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input beats are taken while the queue has room.
    assign o_ready = !w_full;

    aphc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_accept        (i_valid && o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    aphc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_push_entry),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_entry    (w_pop_entry)
    );

    aphc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_nonempty    (w_nonempty),
        .i_q_entry       (w_pop_entry),
        .o_q_pop         (w_pop),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_packet_done   (o_packet_done),
        .o_status        (o_status),
        .o_opcode        (o_opcode),
        .o_request_id    (o_request_id),
        .o_payload_size  (o_payload_size)
    );

endmodule
